FILE: rtl/utf8_ascii_escaper_core_macros.svh
// Assertion macros for the UTF-8 to escaped ASCII converter.
`ifndef UTF8_ASCII_ESCAPER_CORE_MACROS_SVH
`define UTF8_ASCII_ESCAPER_CORE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define UAE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define UAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/uae_pkg.sv
// Types, constants and escape functions for the UTF-8 to escaped ASCII converter.
package uae_pkg;

    // Configuration register indexes
    localparam logic CFG_QUOTE_ESCAPE = 1'b0;
    localparam logic CFG_OUTPUT_LIMIT = 1'b1;

    localparam logic [15:0] OUTPUT_LIMIT_RST = 16'd8185;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_QMARK     = 8'h3f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_DEL       = 8'h7f;

    // One escaped unit: up to six chars, first in the low byte
    typedef struct packed {
        logic [47:0] chars;
        logic [2:0]  len;
    } t_unit;

    // Lowercase hex digit
    function automatic logic [7:0] f_hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

    // Escape of one code point in UTF-8 mode
    function automatic t_unit f_escape_cp(input logic [20:0] u, input logic q);
        t_unit      r;
        logic [4:0] lo;
        logic [1:0] tens;
        logic [3:0] ones;
        r    = '0;
        lo   = (u == 21'd127) ? 5'd27 : u[4:0];
        tens = (lo >= 5'd30) ? 2'd3 : (lo >= 5'd20) ? 2'd2 : (lo >= 5'd10) ? 2'd1 : 2'd0;
        case (tens)
            2'd3:    ones = 4'(lo - 5'd30);
            2'd2:    ones = 4'(lo - 5'd20);
            2'd1:    ones = 4'(lo - 5'd10);
            default: ones = 4'(lo);
        endcase
        if (u == {13'd0, CH_QUOTE} && q) begin
            r.chars[15:0] = {CH_QUOTE, CH_BACKSLASH};
            r.len         = 3'd2;
        end else if (u < 21'd32 || u == {13'd0, CH_DEL}) begin
            // '#' plus three decimal digits
            r.chars[7:0]   = CH_HASH;
            r.chars[15:8]  = (u == {13'd0, CH_DEL}) ? CH_ONE : CH_ZERO;
            r.chars[23:16] = CH_ZERO + {6'd0, tens};
            r.chars[31:24] = CH_ZERO + {4'd0, ones};
            r.len          = 3'd4;
        end else if (u < {13'd0, CH_DEL}) begin
            r.chars[7:0] = u[7:0];
            r.len        = 3'd1;
        end else if (u < 21'h10000) begin
            r.chars[7:0]   = CH_BACKSLASH;
            r.chars[15:8]  = CH_LOWER_U;
            r.chars[23:16] = f_hex_char(u[15:12]);
            r.chars[31:24] = f_hex_char(u[11:8]);
            r.chars[39:32] = f_hex_char(u[7:4]);
            r.chars[47:40] = f_hex_char(u[3:0]);
            r.len          = 3'd6;
        end
        return r;
    endfunction

    // Escape of one byte in raw mode; controls match the three-digit form
    function automatic t_unit f_escape_raw(input logic [7:0] c, input logic q);
        t_unit r;
        r = '0;
        if (c >= CH_DEL) begin
            r.chars[7:0] = CH_QMARK;
            r.len        = 3'd1;
        end else begin
            r = f_escape_cp({13'd0, c}, q);
        end
        return r;
    endfunction

endpackage

FILE: rtl/utf8_ascii_escaper_core.sv
// Top level of the UTF-8 to escaped ASCII converter: input register, escape logic, result register.
// An accepted byte goes through the input register, then the result register, to its result beat.
// One byte per cycle unless i_stall holds; input stage refills in the cycle the result register frees.
// Bytes that complete no unit give no result beat, unless they end the message.
// Reset (i_rst_n low, synchronous): both stages empty, all conversion state zero,
// quote escaping off and the output limit at 8185.
`include "utf8_ascii_escaper_core_macros.svh"

module utf8_ascii_escaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_raw_mode,
    input  logic        i_last_byte,
    // result beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_out_chars,
    output logic [2:0]  o_out_len,
    output logic        o_end_of_message
);

    // configuration registers
    logic        r_quote_escape;
    logic [15:0] r_output_limit;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_raw;
    logic        r_last;

    // conversion state
    logic [15:0] r_chars_written, n_chars_written;
    logic [20:0] r_code_point_acc, n_code_point_acc;
    logic [1:0]  r_bytes_pending, n_bytes_pending;

    // result stage
    logic        r_out_valid;
    logic [47:0] r_out_chars;
    logic [2:0]  r_out_len;
    logic        r_out_eom;

    logic            out_free;
    logic            adv;
    logic            room;
    logic            raw_go;
    logic            cp_go;
    logic [20:0]     cp;
    logic [16:0]     total;
    uae_pkg::t_unit  unit;

    // pipeline handshake
    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_escape <= 1'b0;
            r_output_limit <= uae_pkg::OUTPUT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                uae_pkg::CFG_QUOTE_ESCAPE: r_quote_escape <= i_cfg_data[0];
                uae_pkg::CFG_OUTPUT_LIMIT: r_output_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_in_byte;
            r_raw  <= i_raw_mode;
            r_last <= i_last_byte;
        end
    end

    // decode, code point gathering and state update
    always_comb begin
        n_chars_written  = r_chars_written;
        n_code_point_acc = r_code_point_acc;
        n_bytes_pending  = r_bytes_pending;
        room             = r_chars_written < r_output_limit;
        raw_go           = 1'b0;
        cp_go            = 1'b0;
        cp               = {13'd0, r_byte};
        if (r_raw) begin
            n_code_point_acc = '0;
            n_bytes_pending  = '0;
            raw_go           = room;
        end else if (!r_byte[7]) begin
            n_code_point_acc = '0;
            n_bytes_pending  = '0;
            cp_go            = room;
        end else if (r_byte[7:6] == 2'b10) begin
            // continuation byte; ignored when nothing is pending
            if (r_bytes_pending != 2'd0) begin
                cp               = {r_code_point_acc[14:0], r_byte[5:0]};
                n_code_point_acc = cp;
                n_bytes_pending  = r_bytes_pending - 2'd1;
                if (r_bytes_pending == 2'd1) begin
                    cp_go            = room;
                    n_code_point_acc = '0;
                end
            end
        end else if (r_byte[7:5] == 3'b110) begin
            n_code_point_acc = {16'd0, r_byte[4:0]};
            n_bytes_pending  = 2'd1;
        end else if (r_byte[7:4] == 4'b1110) begin
            n_code_point_acc = {17'd0, r_byte[3:0]};
            n_bytes_pending  = 2'd2;
        end else if (r_byte[7:3] == 5'b11110) begin
            n_code_point_acc = {18'd0, r_byte[2:0]};
            n_bytes_pending  = 2'd3;
        end else begin
            n_code_point_acc = '0;
            n_bytes_pending  = '0;
        end

        if (raw_go) begin
            unit = uae_pkg::f_escape_raw(r_byte, r_quote_escape);
        end else if (cp_go) begin
            unit = uae_pkg::f_escape_cp(cp, r_quote_escape);
        end else begin
            unit = '0;
        end

        // saturating output count
        total           = {1'b0, r_chars_written} + {14'd0, unit.len};
        n_chars_written = total[16] ? 16'hffff : total[15:0];

        if (r_last) begin
            n_chars_written  = '0;
            n_code_point_acc = '0;
            n_bytes_pending  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_written  <= '0;
            r_code_point_acc <= '0;
            r_bytes_pending  <= '0;
        end else if (adv) begin
            r_chars_written  <= n_chars_written;
            r_code_point_acc <= n_code_point_acc;
            r_bytes_pending  <= n_bytes_pending;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv && (unit.len != 3'd0 || r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_chars <= unit.chars;
            r_out_len   <= unit.len;
            r_out_eom   <= r_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_chars      = r_out_chars;
    assign o_out_len        = r_out_len;
    assign o_end_of_message = r_out_eom;

    // checks
    `UAE_ASSERT_RST(a_no_empty_beat, o_valid && !o_end_of_message |-> |o_out_len, "empty beat")
    `UAE_ASSERT_RST(a_clear_after_last, adv && r_last |=> r_chars_written == '0, "not cleared")
    `UAE_ASSERT(a_stall_needs_item, o_stall |-> r_in_valid, "stall with empty stage")

endmodule

FILE: tb/utf8_ascii_escaper_core_tb.sv
// Self-checking testbench for the UTF-8 to escaped ASCII converter core.
`timescale 1ns / 100ps

module utf8_ascii_escaper_core_tb;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 10;
    localparam int DRAIN_CYCLES  = 8;     // two-stage pipe plus margin
    localparam int STALL_LIMIT   = 5000;  // cycles with no beat and no write

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_wr_en      = 1'b0;
    logic        i_cfg_index      = uae_pkg::CFG_QUOTE_ESCAPE;
    logic [15:0] i_cfg_data       = '0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte        = '0;
    logic        i_raw_mode       = 1'b0;
    logic        i_last_byte      = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [47:0] o_out_chars;
    logic [2:0]  o_out_len;
    logic        o_end_of_message;

    // One escaped unit as it should leave the block
    typedef struct packed {
        logic [47:0] chars;
        logic [2:0]  len;
        logic        eom;
    } t_esc_beat;

    t_esc_beat   escaped_units_due[$];
    logic [8:0]  msg_bytes[$];          // {raw flag, byte} of the message being built

    // Converter state as the block should hold it
    logic        esc_quote;
    logic [15:0] esc_limit;
    logic [15:0] esc_written;
    logic [20:0] esc_cp;
    logic [1:0]  esc_pending;

    // Scratch for the unit being assembled
    logic [47:0] unit_chars;
    logic [2:0]  unit_len;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          idle_cycles   = 0;
    int unsigned err_count     = 0;

    utf8_ascii_escaper_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .i_raw_mode       (i_raw_mode),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_chars      (o_out_chars),
        .o_out_len        (o_out_len),
        .o_end_of_message (o_end_of_message)
    );

    always #CLK_HALF i_clk = ~i_clk;

    //--------------------------------------------------------------------
    // Escape rules
    //--------------------------------------------------------------------

    function automatic void put_ch(input logic [7:0] c);
        if (unit_len < 3'd6) begin
            unit_chars[8*unit_len +: 8] = c;
            unit_len = unit_len + 3'd1;
        end
    endfunction

    function automatic logic [7:0] nibble_ch(input logic [3:0] d);
        // 8'h61 is 'a'
        return (d < 4'd10) ? uae_pkg::CH_ZERO + {4'd0, d} : 8'h61 + {4'd0, d} - 8'd10;
    endfunction

    function automatic void escape_code_point(input logic [20:0] u);
        if (u == 21'(uae_pkg::CH_QUOTE) && esc_quote) begin
            put_ch(uae_pkg::CH_BACKSLASH);
            put_ch(uae_pkg::CH_QUOTE);
        end else if (u < 21'd32 || u == 21'(uae_pkg::CH_DEL)) begin
            put_ch(uae_pkg::CH_HASH);
            put_ch(uae_pkg::CH_ZERO + 8'(u / 100));
            put_ch(uae_pkg::CH_ZERO + 8'((u / 10) % 10));
            put_ch(uae_pkg::CH_ZERO + 8'(u % 10));
        end else if (u < 21'(uae_pkg::CH_DEL)) begin
            put_ch(u[7:0]);
        end else if (u < 21'h10000) begin
            put_ch(uae_pkg::CH_BACKSLASH);
            put_ch(uae_pkg::CH_LOWER_U);
            put_ch(nibble_ch(u[15:12]));
            put_ch(nibble_ch(u[11:8]));
            put_ch(nibble_ch(u[7:4]));
            put_ch(nibble_ch(u[3:0]));
        end
    endfunction

    function automatic void escape_raw_byte(input logic [7:0] c);
        if (c == uae_pkg::CH_QUOTE && esc_quote) begin
            put_ch(uae_pkg::CH_BACKSLASH);
            put_ch(uae_pkg::CH_QUOTE);
        end else if (c < 8'd32) begin
            put_ch(uae_pkg::CH_HASH);
            put_ch(uae_pkg::CH_ZERO);
            put_ch(uae_pkg::CH_ZERO + 8'((c / 10) % 10));
            put_ch(uae_pkg::CH_ZERO + 8'(c % 10));
        end else if (c < uae_pkg::CH_DEL) begin
            put_ch(c);
        end else begin
            put_ch(uae_pkg::CH_QMARK);
        end
    endfunction

    // Advance the converter state by one accepted byte, queue the unit it yields
    function automatic void escape_byte(input logic [7:0] b, input logic raw,
                                        input logic last);
        logic        room;
        logic [16:0] total;
        t_esc_beat   beat;
        room       = esc_written < esc_limit;
        unit_chars = '0;
        unit_len   = '0;
        if (raw) begin
            esc_pending = '0;
            esc_cp      = '0;
            if (room) escape_raw_byte(b);
        end else if (b < 8'h80) begin
            esc_pending = '0;
            esc_cp      = '0;
            if (room) escape_code_point({13'd0, b});
        end else if (b < 8'hc0) begin
            // continuation; ignored when nothing is pending
            if (esc_pending != 2'd0) begin
                esc_cp      = {esc_cp[14:0], b[5:0]};
                esc_pending = esc_pending - 2'd1;
                if (esc_pending == 2'd0) begin
                    if (room) escape_code_point(esc_cp);
                    esc_cp = '0;
                end
            end
        end else if (b < 8'he0) begin
            esc_cp      = {16'd0, b[4:0]};
            esc_pending = 2'd1;
        end else if (b < 8'hf0) begin
            esc_cp      = {17'd0, b[3:0]};
            esc_pending = 2'd2;
        end else if (b < 8'hf8) begin
            esc_cp      = {18'd0, b[2:0]};
            esc_pending = 2'd3;
        end else begin
            esc_cp      = '0;
            esc_pending = '0;
        end
        // saturating character count
        total       = {1'b0, esc_written} + {14'd0, unit_len};
        esc_written = total[16] ? 16'hffff : total[15:0];
        if (last) begin
            esc_written = '0;
            esc_cp      = '0;
            esc_pending = '0;
        end
        if (unit_len != 3'd0 || last) begin
            beat.chars = unit_chars;
            beat.len   = unit_len;
            beat.eom   = last;
            escaped_units_due.push_back(beat);
        end
    endfunction

    //--------------------------------------------------------------------
    // Result check, receiver stalls, idle counter
    //--------------------------------------------------------------------

    task automatic note_mismatch(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : beat_check
        t_esc_beat want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (escaped_units_due.size() == 0) begin
                    $display("%0t: expected no beat, got chars %h len %0d eom %b",
                             $time, o_out_chars, o_out_len, o_end_of_message);
                    err_count++;
                end else begin
                    want = escaped_units_due.pop_front();
                    if (o_out_chars !== want.chars)
                        note_mismatch("out_chars", want.chars, o_out_chars);
                    if (o_out_len !== want.len)
                        note_mismatch("out_len", 48'(want.len), 48'(o_out_len));
                    if (o_end_of_message !== want.eom)
                        note_mismatch("end_of_message", 48'(want.eom),
                                      48'(o_end_of_message));
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Hang detection
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    //--------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------

    function automatic void set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endfunction

    // Queue n bytes of seq, most significant byte first
    function automatic void stage_seq(input logic raw, input logic [31:0] seq,
                                      input int n);
        int i;
        for (i = n - 1; i >= 0; i--) msg_bytes.push_back({raw, seq[8*i +: 8]});
    endfunction

    // Control code or delete: four characters each in UTF-8 mode
    function automatic logic [7:0] control_byte();
        int v;
        v = $urandom_range(32);
        return (v == 32) ? uae_pkg::CH_DEL : 8'(v);
    endfunction

    // One input beat; valid stays up on return so back-to-back beats need no dip
    task automatic send_byte(input logic [7:0] b, input logic raw, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_raw_mode  <= raw;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        escape_byte(b, raw, last);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i][7:0], msg_bytes[i][8], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    // Drop valid, wait for every expected beat, then let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (escaped_units_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [15:0] value);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == uae_pkg::CFG_QUOTE_ESCAPE)
            esc_quote = value[0];
        else
            esc_limit = value;
    endtask

    // Random message: mostly well-formed units, some broken sequences and noise
    task automatic build_random_message();
        int         n_units;
        int         u;
        int         sel;
        int         conts;
        logic       raw_msg;
        logic [7:0] lead;
        raw_msg = ($urandom_range(99) < 20);
        n_units = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (u = 0; u < n_units; u++) begin
            sel = $urandom_range(99);
            if (raw_msg) begin
                if (sel < 25)
                    stage_seq(1'b1, $urandom_range(31), 1);
                else if (sel < 35)
                    stage_seq(1'b1, 32'(uae_pkg::CH_QUOTE), 1);
                else if (sel < 50)
                    stage_seq(1'b1, $urandom_range(255, 127), 1);
                else
                    stage_seq(1'b1, $urandom_range(255), 1);
            end else if (sel < 25) begin
                stage_seq(1'b0, $urandom_range(126, 32), 1);
            end else if (sel < 35) begin
                stage_seq(1'b0, 32'(control_byte()), 1);
            end else if (sel < 42) begin
                stage_seq(1'b0, 32'(uae_pkg::CH_QUOTE), 1);
            end else if (sel < 55) begin
                stage_seq(1'b0, 32'({8'hc0 | 8'($urandom_range(31)),
                                     8'h80 | 8'($urandom_range(63))}), 2);
            end else if (sel < 68) begin
                stage_seq(1'b0, 32'({8'he0 | 8'($urandom_range(15)),
                                     8'h80 | 8'($urandom_range(63)),
                                     8'h80 | 8'($urandom_range(63))}), 3);
            end else if (sel < 76) begin
                stage_seq(1'b0, {8'hf0 | 8'($urandom_range(7)),
                                 8'h80 | 8'($urandom_range(63)),
                                 8'h80 | 8'($urandom_range(63)),
                                 8'h80 | 8'($urandom_range(63))}, 4);
            end else if (sel < 86) begin
                // sequence cut short by whatever follows
                lead = 8'($urandom_range(8'hf7, 8'hc0));
                stage_seq(1'b0, 32'(lead), 1);
                conts = (lead < 8'he0) ? 0 :
                        (lead < 8'hf0) ? $urandom_range(1) : $urandom_range(2);
                repeat (conts) stage_seq(1'b0, 32'(8'h80 | 8'($urandom_range(63))), 1);
            end else if (sel < 92) begin
                stage_seq(1'b0, $urandom_range(8'hbf, 8'h80), 1);
            end else if (sel < 96) begin
                stage_seq(1'b1, $urandom_range(255), 1);
            end else begin
                stage_seq(1'b0, $urandom_range(255), 1);
            end
        end
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------

    task automatic test_utf8_escapes();
        // zero byte, delete, top printable
        stage_seq(1'b0, 32'h007f7e, 3);
        // largest 3-byte point, then a 4-byte point that is dropped
        stage_seq(1'b0, 32'hefbfbf, 3);
        stage_seq(1'b0, 32'hf48fbfbf, 4);
        // stray continuation; a lead cut off by a new 2-byte sequence
        stage_seq(1'b0, 32'h80e2c3a9, 4);
        // F8..FF drops a pending lead
        stage_seq(1'b0, 32'he0ff, 2);
        // message ends inside a sequence: end beat with no chars
        stage_seq(1'b0, 32'hc3, 1);
        send_message();
    endtask

    task automatic test_raw_mode();
        // pending UTF-8 lead cut off by a raw byte
        stage_seq(1'b0, 32'hc3, 1);
        stage_seq(1'b1, 32'h001f227f, 4);
        stage_seq(1'b1, 32'hff, 1);
        send_message();
    endtask

    task automatic test_quote_escape();
        write_config(uae_pkg::CFG_QUOTE_ESCAPE, 16'd1);
        stage_seq(1'b0, 32'(uae_pkg::CH_QUOTE), 1);
        send_message();
        stage_seq(1'b1, 32'(uae_pkg::CH_QUOTE), 1);
        send_message();
    endtask

    task automatic test_output_limit();
        write_config(uae_pkg::CFG_OUTPUT_LIMIT, 16'd4);
        // 3 chars, then a 6-char unit started below the limit, then nothing
        stage_seq(1'b0, 32'h414141, 3);
        stage_seq(1'b0, 32'hefbfbf, 3);
        stage_seq(1'b0, 32'h41, 1);
        send_message();
    endtask

    task automatic test_random_traffic();
        int          ph;
        int          k;
        int          sent;
        logic        q;
        logic [15:0] lim;
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       set_idling(12, 70);
                1:       set_idling(70, 12);
                default: set_idling(0, 0);
            endcase
            for (k = 0; k < 2; k++) begin
                case (2 * ph + k)
                    0: begin q = 1'b1; lim = 16'd4; end
                    1: begin q = 1'b0; lim = 16'hffff; end
                    2: begin q = 1'b1; lim = 16'($urandom_range(64, 5)); end
                    3: begin q = 1'b0; lim = uae_pkg::OUTPUT_LIMIT_RST; end
                    4: begin q = 1'($urandom_range(1)); lim = 16'($urandom_range(120, 4)); end
                    default: begin q = 1'b1; lim = 16'($urandom_range(40, 4)); end
                endcase
                write_config(uae_pkg::CFG_QUOTE_ESCAPE, {15'd0, q});
                write_config(uae_pkg::CFG_OUTPUT_LIMIT, lim);
                sent = 0;
                while (sent < 172) begin
                    build_random_message();
                    sent += msg_bytes.size();
                    send_message();
                end
            end
        end
    endtask

    initial begin
        esc_quote   = 1'b0;
        esc_limit   = uae_pkg::OUTPUT_LIMIT_RST;
        esc_written = '0;
        esc_cp      = '0;
        esc_pending = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(12, 70);
        test_utf8_escapes();
        test_raw_mode();
        test_quote_escape();
        test_output_limit();
        test_random_traffic();

        settle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
